// ----- src/tea_pkg.sv -----
// Shared types and constants for the TEA block cipher unit.
// Used by tea_cell and tea_block_cipher_unit; depends on nothing else.
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned KEY_WORDS = 4;

  // TEA round constant.
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = 3'd3;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tea_op_t;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] tea_key_t;

  typedef struct packed {
    tea_op_t           operation;
    logic [WORD_W-1:0] block_low;
    logic [WORD_W-1:0] block_high;
  } tea_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
  } tea_rsp_t;

  // What one cell hands to the next.
  typedef struct packed {
    tea_op_t           operation;
    logic [WORD_W-1:0] word_low;
    logic [WORD_W-1:0] word_high;
  } tea_stage_t;

endpackage

// ----- src/tea_block_cipher_unit.sv -----
// Top level of the TEA block cipher unit: key registers and the cell chain.
// Depends on tea_pkg and tea_cell.

// This unit encrypts or decrypts 64-bit blocks with TEA under a 128-bit key
// held in four configuration words (all zero after reset). Each request carries
// the operation and the block as two little-endian words; each request yields
// exactly one response, in request order. The datapath is a chain of
// 2*ROUNDS identical cells, each doing one half-round (one word update) and
// registering its result, so a block passes through 2*ROUNDS stage registers
// and a new request can enter every cycle while req_stall is low.
// The last cell's register is the response register. A stage that holds a
// block moves it on only when the next stage is empty or also moving, so
// empty slots close up while the output is stalled and requests keep being
// taken until the chain is full. The key may only be rewritten while no
// block is in flight.
module tea_block_cipher_unit #(
  parameter int ROUNDS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  tea_pkg::tea_req_t                      req,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output tea_pkg::tea_rsp_t                      rsp,
  input  logic                                   cfg_write,
  input  logic [tea_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]             cfg_data
);
  import tea_pkg::*;

  localparam int STEPS = 2 * ROUNDS;

  tea_key_t   key;
  tea_stage_t req_stage;
  logic       stage_valid [STEPS];
  tea_stage_t stage_data [STEPS];
  logic       stage_ready [STEPS+1];

  // Key registers; writes to indexes beyond the key are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY_WORD0: key[0] <= cfg_data;
        CFG_KEY_WORD1: key[1] <= cfg_data;
        CFG_KEY_WORD2: key[2] <= cfg_data;
        CFG_KEY_WORD3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    req_stage.operation = req.operation;
    req_stage.word_low  = req.block_low;
    req_stage.word_high = req.block_high;
  end

  // A stage can take new data when it is empty or its block moves on.
  assign stage_ready[STEPS] = !rsp_stall;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    assign stage_ready[i] = !stage_valid[i] || stage_ready[i+1];

    if (i == 0) begin : g_first
      tea_cell #(
        .ROUNDS (ROUNDS),
        .STEP   (i)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (stage_ready[i]),
        .valid_prev (req_valid),
        .data_prev  (req_stage),
        .key        (key),
        .valid      (stage_valid[i]),
        .data       (stage_data[i])
      );
    end else begin : g_rest
      tea_cell #(
        .ROUNDS (ROUNDS),
        .STEP   (i)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (stage_ready[i]),
        .valid_prev (stage_valid[i-1]),
        .data_prev  (stage_data[i-1]),
        .key        (key),
        .valid      (stage_valid[i]),
        .data       (stage_data[i])
      );
    end
  end

  assign req_stall = !stage_ready[0];
  assign rsp_valid = stage_valid[STEPS-1];

  always_comb begin
    rsp.result_low  = stage_data[STEPS-1].word_low;
    rsp.result_high = stage_data[STEPS-1].word_high;
  end

  // The unit only pushes back when the first cell holds a block it cannot pass on.
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> stage_valid[0])
    else $error("request stalled while the first cell is empty");

  // An accepted request always lands in the first cell.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> stage_valid[0])
    else $error("accepted request was lost at the first cell");

  // A blocked first cell keeps its block unchanged.
  a_first_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[0] && !stage_ready[0]) |=> (stage_valid[0] && $stable(stage_data[0])))
    else $error("first cell changed while blocked");

endmodule

// ----- src/tea_cell.sv -----
// One TEA half-round cell of the cipher pipeline, with its stage register.
// Depends on tea_pkg.
module tea_cell #(
  parameter int ROUNDS = 32,
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               valid_prev,
  input  tea_pkg::tea_stage_t data_prev,
  input  tea_pkg::tea_key_t  key,
  output logic               valid,
  output tea_pkg::tea_stage_t data
);
  import tea_pkg::*;

  localparam int ROUND_IDX = STEP / 2;
  localparam bit FIRST_HALF = (STEP % 2) == 0;
  localparam logic [63:0] ENC_PROD = 64'(TEA_DELTA) * 64'(ROUND_IDX + 1);
  localparam logic [63:0] DEC_PROD = 64'(TEA_DELTA) * 64'(ROUNDS - ROUND_IDX);
  localparam logic [WORD_W-1:0] ENC_SUM = ENC_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0] DEC_SUM = DEC_PROD[WORD_W-1:0];

  logic              encrypt;
  logic              upd_low;
  logic [WORD_W-1:0] src_word;
  logic [WORD_W-1:0] dst_word;
  logic [WORD_W-1:0] key_a;
  logic [WORD_W-1:0] key_b;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] dst_new;
  tea_stage_t        data_next;

  // Encryption updates the low word first, decryption the high word first.
  always_comb begin
    encrypt  = (data_prev.operation == OP_ENCRYPT);
    upd_low  = (encrypt == FIRST_HALF);
    src_word = upd_low ? data_prev.word_high : data_prev.word_low;
    dst_word = upd_low ? data_prev.word_low : data_prev.word_high;
    key_a    = upd_low ? key[0] : key[2];
    key_b    = upd_low ? key[1] : key[3];
    sum      = encrypt ? ENC_SUM : DEC_SUM;
    mix      = ((src_word << 4) + key_a) ^ (src_word + sum) ^ ((src_word >> 5) + key_b);
    dst_new  = encrypt ? (dst_word + mix) : (dst_word - mix);
    data_next = data_prev;
    if (upd_low) begin
      data_next.word_low = dst_new;
    end else begin
      data_next.word_high = dst_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= data_next;
    end
  end

endmodule

// ----- tb/tb_tea_block_cipher_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tea_block_cipher_unit: TEA encrypt and decrypt under
// reset, extreme and random keys, with bursty requests and a stalling receiver.
// Depends on tea_pkg and the unit's RTL only.
module tb_tea_block_cipher_unit;
  import tea_pkg::*;

  // The unit runs with its default round count; the predictor uses the same value.
  localparam int TEA_ROUNDS = 32;
  // One cell per half-round, so this is the number of cells in the chain.
  localparam int CHAIN_DEPTH = 2 * TEA_ROUNDS;
  // Generous bound on the whole run, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 125;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  localparam logic [CFG_INDEX_W-1:0] KEY_INDEX [KEY_WORDS] =
    '{CFG_KEY_WORD0, CFG_KEY_WORD1, CFG_KEY_WORD2, CFG_KEY_WORD3};

  // How hard the receiver pushes back on responses.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  tea_req_t               req;
  logic                   rsp_valid;
  logic                   rsp_stall;
  tea_rsp_t               rsp;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  // The testbench's own copy of the key registers.
  tea_key_t    key_copy;
  // Ciphertext or plaintext still owed by the unit, oldest first.
  tea_rsp_t    pending_blocks[$];
  tea_rsp_t    rsp_want;
  int          error_count;
  int          cycle_count;

  // Sender pacing: when gaps are on, requests go out in bursts separated by idle gaps.
  bit          gaps_on;
  int          gap_max;
  int          burst_left;

  // Receiver pacing: stall runs of random level and length.
  stall_mode_t stall_mode;
  int          stall_run;
  logic        stall_level;

  tea_block_cipher_unit #(
    .ROUNDS(TEA_ROUNDS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One TEA half-round mixing term; all arithmetic wraps at 32 bits.
  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] v,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    logic [WORD_W-1:0] shl;
    logic [WORD_W-1:0] shr;
    shl = v << 4;
    shr = v >> 5;
    return (shl + ka) ^ (v + sum) ^ (shr + kb);
  endfunction

  // Full block transform under the current key copy. Decryption starts from
  // delta times the round count so that it undoes encryption exactly.
  function automatic tea_rsp_t tea_transform(input tea_req_t blk);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    tea_rsp_t          out;
    v0 = blk.block_low;
    v1 = blk.block_high;
    if (blk.operation == OP_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        sum = sum + TEA_DELTA;
        v0 = v0 + tea_mix(v1, sum, key_copy[0], key_copy[1]);
        v1 = v1 + tea_mix(v0, sum, key_copy[2], key_copy[3]);
      end
    end else begin
      sum = WORD_W'(TEA_DELTA * WORD_W'(TEA_ROUNDS));
      for (int r = 0; r < TEA_ROUNDS; r++) begin
        v1 = v1 - tea_mix(v0, sum, key_copy[2], key_copy[3]);
        v0 = v0 - tea_mix(v1, sum, key_copy[0], key_copy[1]);
        sum = sum - TEA_DELTA;
      end
    end
    out.result_low  = v0;
    out.result_high = v1;
    return out;
  endfunction

  function automatic tea_req_t make_block(input tea_op_t op, input logic [WORD_W-1:0] lo,
                                          input logic [WORD_W-1:0] hi);
    tea_req_t blk;
    blk.operation  = op;
    blk.block_low  = lo;
    blk.block_high = hi;
    return blk;
  endfunction

  // Mostly uniform words, with all-zero and all-one words mixed in now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return ALL_ONES;
    end
    return $urandom;
  endfunction

  // Drives one request at a falling edge and holds it until the unit takes it.
  // The expected response is queued at the accepting edge, with the key that
  // is live then.
  task automatic send_block(input tea_req_t blk);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, gap_max);
        repeat (gap) begin
          @(negedge clk);
          req_valid <= 1'b0;
        end
      end
      burst_left--;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= blk;
    do begin
      @(posedge clk);
    end while (req_stall);
    pending_blocks.push_back(tea_transform(blk));
  endtask

  // Stops sending, waits until every owed response is back, then lets the
  // chain's depth pass so that nothing unexpected can still be on its way.
  task automatic drain_unit();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_blocks.size() != 0) begin
      @(posedge clk);
    end
    repeat (CHAIN_DEPTH) @(posedge clk);
  endtask

  // Register write; only legal while the unit is empty. Indexes beyond the
  // key leave the key copy alone, as they should leave the unit alone.
  task automatic write_key(input logic [CFG_INDEX_W-1:0] index,
                           input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      CFG_KEY_WORD0: key_copy[0] = data;
      CFG_KEY_WORD1: key_copy[1] = data;
      CFG_KEY_WORD2: key_copy[2] = data;
      CFG_KEY_WORD3: key_copy[3] = data;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_pacing(input bit gaps, input int gmax, input stall_mode_t mode);
    gaps_on    = gaps;
    gap_max    = gmax;
    burst_left = 0;
    stall_mode = mode;
  endtask

  // The key is all zero after reset; blocks at the word extremes both ways.
  task automatic test_reset_key();
    set_pacing(1'b0, 1, STALL_NONE);
    send_block(make_block(OP_ENCRYPT, '0, '0));
    send_block(make_block(OP_ENCRYPT, ALL_ONES, ALL_ONES));
    send_block(make_block(OP_DECRYPT, '0, '0));
    send_block(make_block(OP_DECRYPT, ALL_ONES, ALL_ONES));
    send_block(make_block(OP_ENCRYPT, '0, ALL_ONES));
    send_block(make_block(OP_DECRYPT, ALL_ONES, '0));
    drain_unit();
  endtask

  // All-one key, then a patterned key with a round trip: the ciphertext the
  // predictor expects is fed back in for decryption.
  task automatic test_key_extremes();
    tea_rsp_t cipher;
    for (int i = 0; i < KEY_WORDS; i++) begin
      write_key(KEY_INDEX[i], ALL_ONES);
    end
    set_pacing(1'b1, 3, STALL_LIGHT);
    send_block(make_block(OP_ENCRYPT, '0, '0));
    send_block(make_block(OP_ENCRYPT, ALL_ONES, ALL_ONES));
    send_block(make_block(OP_DECRYPT, '0, ALL_ONES));
    send_block(make_block(OP_DECRYPT, ALL_ONES, '0));
    drain_unit();
    write_key(CFG_KEY_WORD0, 32'h0123_4567);
    write_key(CFG_KEY_WORD1, 32'h89AB_CDEF);
    write_key(CFG_KEY_WORD2, 32'hFEDC_BA98);
    write_key(CFG_KEY_WORD3, 32'h7654_3210);
    cipher = tea_transform(make_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555));
    send_block(make_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555));
    send_block(make_block(OP_DECRYPT, cipher.result_low, cipher.result_high));
    cipher = tea_transform(make_block(OP_ENCRYPT, 32'h8000_0001, 32'h0000_0001));
    send_block(make_block(OP_ENCRYPT, 32'h8000_0001, 32'h0000_0001));
    send_block(make_block(OP_DECRYPT, cipher.result_low, cipher.result_high));
    drain_unit();
  endtask

  // Writes above the last key word must not disturb the key.
  task automatic test_ignored_index();
    for (int i = int'(CFG_KEY_WORD3) + 1; i < (1 << CFG_INDEX_W); i++) begin
      write_key(CFG_INDEX_W'(i), $urandom);
    end
    set_pacing(1'b0, 1, STALL_HEAVY);
    send_block(make_block(OP_ENCRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D));
    send_block(make_block(OP_DECRYPT, 32'hDEAD_BEEF, 32'h0BAD_F00D));
    drain_unit();
  endtask

  // Phases of random blocks. Each phase loads a fresh key, with words that are
  // sometimes zero or all ones, and its own sender and receiver pacing. The
  // first phase runs with no idling on either side to keep the chain full.
  task automatic test_random_traffic();
    int       sel;
    tea_req_t blk;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        sel = $urandom_range(0, 3);
        if (sel == 0) begin
          write_key(KEY_INDEX[i], '0);
        end else if (sel == 1) begin
          write_key(KEY_INDEX[i], ALL_ONES);
        end else begin
          write_key(KEY_INDEX[i], $urandom);
        end
      end
      if (p == 0) begin
        set_pacing(1'b0, 1, STALL_NONE);
      end else begin
        set_pacing(1'($urandom_range(0, 1)), $urandom_range(1, 20),
                   stall_mode_t'($urandom_range(0, 2)));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        blk = make_block(tea_op_t'($urandom_range(0, 1)), pick_word(), pick_word());
        send_block(blk);
      end
      drain_unit();
    end
  endtask

  // Receiver: picks a stall level and holds it for a run of random length.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      case (stall_mode)
        STALL_LIGHT: begin
          stall_level = ($urandom_range(0, 3) == 0);
          stall_run   = $urandom_range(1, 3);
        end
        STALL_HEAVY: begin
          stall_level = 1'($urandom_range(0, 1));
          stall_run   = $urandom_range(1, 30);
        end
        default: begin
          stall_level = 1'b0;
          stall_run   = 1;
        end
      endcase
    end
    stall_run--;
    rsp_stall <= stall_level;
  end

  // Every accepted response is checked against the oldest owed block.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_blocks.size() == 0) begin
        $error("response with nothing owed: result_low %h result_high %h",
               rsp.result_low, rsp.result_high);
        error_count++;
      end else begin
        rsp_want = pending_blocks.pop_front();
        if (rsp.result_low !== rsp_want.result_low) begin
          $error("result_low expected %h actual %h", rsp_want.result_low, rsp.result_low);
          error_count++;
        end
        if (rsp.result_high !== rsp_want.result_high) begin
          $error("result_high expected %h actual %h", rsp_want.result_high, rsp.result_high);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung unit must not hang the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses owed",
               cycle_count, pending_blocks.size());
      $display("[tea_block_cipher_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    rsp_stall   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    key_copy    = '0;
    error_count = 0;
    cycle_count = 0;
    stall_run   = 0;
    stall_level = 1'b0;
    set_pacing(1'b0, 1, STALL_NONE);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_key();
    test_key_extremes();
    test_ignored_index();
    test_random_traffic();

    if (error_count == 0 && pending_blocks.size() == 0) begin
      $display("[tea_block_cipher_unit] OK");
    end else begin
      $display("[tea_block_cipher_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tea_pkg.sv
src/tea_cell.sv
src/tea_block_cipher_unit.sv
tb/tb_tea_block_cipher_unit.sv
